// File: rtl/tdet_pkg.sv
package tdet_pkg;

  localparam int MAX_SLOTS_DEF = 128;
  localparam int SLOT_UNITS    = 230400;
  localparam int SLOT_SH       = 10;
  localparam int SLOT_DIV      = 225;
  localparam int SLOT_RECIP    = 4772186;
  localparam int SLOT_RECIP_SH = 30;
  localparam int TSLOT_W       = 15;
  localparam int DIV_DW        = 40;
  localparam int DIV_RW        = 24;
  localparam int TO_NEXT_W     = 18;
  localparam int SPEED_W       = 24;
  localparam int TIME_W        = 40;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [6:0]         slot_index;
    logic signed [23:0] slot_speed;
    logic               edge_found;
    logic [31:0]        edge_length;
    logic signed [31:0] avg_time;
    logic [31:0]        start_time;
    logic [7:0]         slot_count;
  } in_t;

  typedef struct packed {
    logic [39:0] travel_time;
    logic        unreachable;
  } out_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quo;
    logic [DIV_RW-1:0] rem;
  } div_res_t;

endpackage

// File: rtl/time_dependent_edge_travel_time.sv
// Travel time of one edge under a speed profile of 15-minute slots.
// An input transfer is taken when start is high and busy is low. A write
// command stores one slot speed in the profile memory and gives no result;
// busy stays low. A query that ends before the walk (missing edge, empty
// profile, zero length) shows its result in the next cycle without raising
// busy. Any other query raises busy until its result is shown.
// The result appears on out_data for exactly one cycle with out_valid high;
// the receiver cannot stall it, so busy falls in that same cycle and the
// next transfer may be taken at the edge that ends it.
// The entry time is split into slot number and offset by a reciprocal
// multiply, then one pass of the shared 40-step divider reduces the slot
// number modulo the slot count. Each slot visited costs a memory read, one
// divider pass for the time needed and a multiply. A slot without a usable
// speed ends the walk early.
// Reset clears the sequencer and the result strobe; the profile memory is not
// cleared and must be written before a query reads a slot.
module time_dependent_edge_travel_time #(
  parameter int MAX_SLOTS = tdet_pkg::MAX_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  tdet_pkg::in_t  in_data,
  output logic           out_valid,
  output tdet_pkg::out_t out_data
);
  import tdet_pkg::*;

  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int IW = $clog2(2 * MAX_SLOTS + 101);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIVT = 4'd1;
  localparam logic [3:0] S_DIVS = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_SPD  = 4'd4;
  localparam logic [3:0] S_NEED = 4'd5;
  localparam logic [3:0] S_UPD  = 4'd6;
  localparam logic [3:0] S_OFF  = 4'd7;

  logic [3:0]           state_r, state_nxt;
  logic [31:0]          len_r, len_nxt;
  logic signed [31:0]   avg_r, avg_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [SW-1:0]        slot_r, slot_nxt;
  logic [TO_NEXT_W-1:0] off_r, off_nxt;
  logic [TO_NEXT_W-1:0] tonx_r, tonx_nxt;
  logic [SPEED_W-1:0]   sp_r, sp_nxt;
  logic [41:0]          prod_r, prod_nxt;
  logic [TIME_W:0]      taken_r, taken_nxt;
  logic [IW-1:0]        iter_r, iter_nxt;
  logic [31:0]          tstart_r, tstart_nxt;
  logic [TSLOT_W-1:0]   tslot_r, tslot_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;

  logic                 div_go;
  logic [DIV_DW-1:0]    div_a;
  logic [DIV_RW-1:0]    div_b;
  div_res_t             div_res;

  logic                 wr_en;
  logic [SPEED_W-1:0]   rd_speed;
  logic                 accept;
  logic [CW-1:0]        cnt_in;
  logic [TIME_W:0]      tk_fit;
  logic [IW-1:0]        max_iter, iter_inc;
  logic [CW-1:0]        slot_inc;
  logic [44:0]          recip_prod;
  logic [21:0]          off_hi;
  out_t                 fb;

  assign accept = start && !busy;
  assign wr_en  = accept && (in_data.cmd == CMD_WRITE)
                  && (32'(in_data.slot_index) < 32'(MAX_SLOTS));

  tdet_ram #(.WIDTH(SPEED_W), .DEPTH(MAX_SLOTS), .AW(SW)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (SW'(in_data.slot_index)),
    .wdata (in_data.slot_speed),
    .raddr (slot_r),
    .rdata (rd_speed)
  );

  tdet_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .res      (div_res)
  );

  assign cnt_in   = (32'(in_data.slot_count) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS)
                                                              : CW'(in_data.slot_count);
  assign max_iter = IW'({cnt_r, 1'b0}) + IW'(100);
  assign iter_inc = iter_r + IW'(1);
  assign slot_inc = CW'(slot_r) + CW'(1);
  assign tk_fit   = taken_r + (TIME_W + 1)'(div_res.quo);

  assign recip_prod = 45'(tstart_r[31:SLOT_SH]) * 45'(SLOT_RECIP);
  assign off_hi     = tstart_r[31:SLOT_SH] - 22'(tslot_r) * 22'(SLOT_DIV);

  always_comb begin
    if (!avg_r[31] && (avg_r != 32'sd0)) begin
      fb.travel_time = 40'(unsigned'(avg_r));
      fb.unreachable = 1'b0;
    end else begin
      fb.travel_time = '0;
      fb.unreachable = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    avg_nxt       = avg_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    off_nxt       = off_r;
    tonx_nxt      = tonx_r;
    sp_nxt        = sp_r;
    prod_nxt      = prod_r;
    taken_nxt     = taken_r;
    iter_nxt      = iter_r;
    tstart_nxt    = tstart_r;
    tslot_nxt     = tslot_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    div_go        = 1'b0;
    div_a         = '0;
    div_b         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_data.cmd == CMD_QUERY)) begin
          len_nxt   = in_data.edge_length;
          avg_nxt   = in_data.avg_time;
          cnt_nxt   = cnt_in;
          taken_nxt = '0;
          iter_nxt  = '0;
          if (!in_data.edge_found) begin
            out_valid_nxt       = 1'b1;
            out_nxt.travel_time = '0;
            out_nxt.unreachable = 1'b1;
          end else if (cnt_in == '0) begin
            out_valid_nxt = 1'b1;
            if (!in_data.avg_time[31] && (in_data.avg_time != 32'sd0)) begin
              out_nxt.travel_time = 40'(unsigned'(in_data.avg_time));
              out_nxt.unreachable = 1'b0;
            end else begin
              out_nxt.travel_time = '0;
              out_nxt.unreachable = 1'b1;
            end
          end else if (in_data.edge_length == '0) begin
            out_valid_nxt       = 1'b1;
            out_nxt.travel_time = '0;
            out_nxt.unreachable = 1'b0;
          end else begin
            tstart_nxt = in_data.start_time;
            state_nxt  = S_DIVT;
          end
        end
      end
      S_DIVT: begin
        tslot_nxt = recip_prod[SLOT_RECIP_SH +: TSLOT_W];
        state_nxt = S_OFF;
      end
      S_OFF: begin
        off_nxt   = {off_hi[7:0], tstart_r[SLOT_SH-1:0]};
        div_go    = 1'b1;
        div_a     = DIV_DW'(tslot_r);
        div_b     = DIV_RW'(cnt_r);
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        if (div_res.done) begin
          slot_nxt  = SW'(div_res.rem);
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_SPD;
      end
      S_SPD: begin
        if (rd_speed[SPEED_W-1] || (rd_speed == '0)) begin
          out_valid_nxt = 1'b1;
          out_nxt       = fb;
          state_nxt     = S_IDLE;
        end else begin
          sp_nxt    = rd_speed;
          tonx_nxt  = TO_NEXT_W'(SLOT_UNITS) - off_r;
          div_go    = 1'b1;
          div_a     = {len_r, 8'b0};
          div_b     = rd_speed;
          state_nxt = S_NEED;
        end
      end
      S_NEED: begin
        if (div_res.done) begin
          if (div_res.quo <= DIV_DW'(tonx_r)) begin
            out_valid_nxt = 1'b1;
            if (tk_fit[TIME_W]) begin
              out_nxt.travel_time = '0;
              out_nxt.unreachable = 1'b1;
            end else begin
              out_nxt.travel_time = tk_fit[TIME_W-1:0];
              out_nxt.unreachable = 1'b0;
            end
            state_nxt = S_IDLE;
          end else begin
            prod_nxt  = 42'(sp_r) * 42'(tonx_r);
            taken_nxt = taken_r + (TIME_W + 1)'(tonx_r);
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        len_nxt  = len_r - prod_r[39:8];
        iter_nxt = iter_inc;
        if (taken_r[TIME_W] || (iter_inc >= max_iter)) begin
          out_valid_nxt       = 1'b1;
          out_nxt.travel_time = '0;
          out_nxt.unreachable = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          off_nxt   = '0;
          slot_nxt  = (slot_inc == cnt_r) ? '0 : SW'(slot_inc);
          state_nxt = S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    len_r    <= len_nxt;
    avg_r    <= avg_nxt;
    cnt_r    <= cnt_nxt;
    slot_r   <= slot_nxt;
    off_r    <= off_nxt;
    tonx_r   <= tonx_nxt;
    sp_r     <= sp_nxt;
    prod_r   <= prod_nxt;
    taken_r  <= taken_nxt;
    iter_r   <= iter_nxt;
    tstart_r <= tstart_nxt;
    tslot_r  <= tslot_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/tdet_ram.sv
module tdet_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tdet_div.sv
module tdet_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [tdet_pkg::DIV_DW-1:0] dividend,
  input  logic [tdet_pkg::DIV_RW-1:0] divisor,
  output tdet_pkg::div_res_t          res
);
  import tdet_pkg::*;

  localparam int CNT_W = $clog2(DIV_DW + 1);

  logic [DIV_DW-1:0] dvd_r, quo_r;
  logic [DIV_RW:0]   rem_r;
  logic [DIV_RW-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r, done_r;
  logic [DIV_RW:0]   rem_sh, rem_sub;
  logic              ge;

  assign rem_sh  = {rem_r[DIV_RW-1:0], dvd_r[DIV_DW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DIV_DW);
        dvd_r <= dividend;
        dvs_r <= divisor;
        rem_r <= '0;
        quo_r <= '0;
      end else if (run_r) begin
        dvd_r <= {dvd_r[DIV_DW-2:0], 1'b0};
        rem_r <= ge ? rem_sub : rem_sh;
        quo_r <= {quo_r[DIV_DW-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r[DIV_RW-1:0];

endmodule

// File: dv/tb_time_dependent_edge_travel_time.sv
module tb_time_dependent_edge_travel_time;
  timeunit 1ns;
  timeprecision 1ps;

  import tdet_pkg::*;

  localparam longint unsigned TIME_LIMIT = 64'hFF_FFFF_FFFF;
  localparam longint unsigned SLOT_LEN   = 230400;
  localparam longint          RUN_LIMIT  = 100000000;
  localparam int              IN_W       = $bits(in_t);

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  logic signed [23:0] profile [128];
  out_t               pending_times [$];
  int                 errors;
  longint             cycles;

  time_dependent_edge_travel_time dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic out_t average_or_unreachable(logic signed [31:0] avg);
    out_t r;
    r = '0;
    if (avg > 0) r.travel_time = 40'(avg);
    else r.unreachable = 1'b1;
    return r;
  endfunction

  function automatic out_t travel_estimate(in_t q);
    longint unsigned len, t, cnt, taken, iter, max_iter, slot, sp, to_next, need;
    longint s;
    out_t r;
    r = '0;
    if (!q.edge_found) begin
      r.unreachable = 1'b1;
      return r;
    end
    cnt = q.slot_count;
    if (cnt > 128) cnt = 128;
    if (cnt == 0) return average_or_unreachable(q.avg_time);
    len = q.edge_length;
    if (len == 0) return r;
    t = q.start_time;
    taken = 0;
    iter = 0;
    max_iter = cnt * 2 + 100;
    while (len > 0 && iter < max_iter) begin
      slot = (t / SLOT_LEN) % cnt;
      s = profile[slot];
      if (s <= 0) return average_or_unreachable(q.avg_time);
      sp = s;
      to_next = SLOT_LEN - (t % SLOT_LEN);
      need = (len << 8) / sp;
      if (need <= to_next) begin
        taken += need;
        len = 0;
      end else begin
        taken += to_next;
        len -= (sp * to_next) >> 8;
        t += to_next;
      end
      if (taken > TIME_LIMIT) begin
        r.unreachable = 1'b1;
        return r;
      end
      iter++;
    end
    if (len > 0) r.unreachable = 1'b1;
    else r.travel_time = taken[39:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_times.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_r = pending_times.pop_front();
        if (out_data.travel_time !== exp_r.travel_time) begin
          $display("%0t: travel_time expected %0d actual %0d", $time,
                   exp_r.travel_time, out_data.travel_time);
          errors++;
        end
        if (out_data.unreachable !== exp_r.unreachable) begin
          $display("%0t: unreachable expected %0d actual %0d", $time,
                   exp_r.unreachable, out_data.unreachable);
          errors++;
        end
      end
    end
  end

  task automatic send_item(in_t item);
    while (busy) @(negedge clk);
    start = 1'b1;
    in_data = item;
    @(posedge clk);
    if (item.cmd == CMD_WRITE) profile[item.slot_index] = item.slot_speed;
    else pending_times = {pending_times, travel_estimate(item)};
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(negedge clk);
  endtask

  function automatic in_t noise_item();
    in_t it;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    return it;
  endfunction

  task automatic write_speed(int idx, logic signed [23:0] spd);
    in_t it;
    it = noise_item();
    it.cmd = CMD_WRITE;
    it.slot_index = 7'(idx);
    it.slot_speed = spd;
    send_item(it);
  endtask

  task automatic query(logic found, logic [31:0] len, logic signed [31:0] avg,
                       logic [31:0] t0, logic [7:0] cnt);
    in_t it;
    it = noise_item();
    it.cmd = CMD_QUERY;
    it.edge_found = found;
    it.edge_length = len;
    it.avg_time = avg;
    it.start_time = t0;
    it.slot_count = cnt;
    send_item(it);
  endtask

  function automatic logic signed [23:0] random_speed();
    case ($urandom_range(0, 19))
      0: return -24'($urandom_range(0, 8388608));
      1: return 24'($urandom_range(1, 300));
      default: return 24'($urandom_range(1 << 18, 8388607));
    endcase
  endfunction

  task automatic test_fill_profile();
    for (int i = 0; i < 128; i++) begin
      write_speed(i, 24'($urandom_range(1 << 16, 8388607)));
      idle_gap();
    end
  endtask

  task automatic test_directed();
    query(1'b0, 32'd1000, 32'sd50, 32'd0, 8'd4);
    query(1'b1, 32'd1000, 32'sd77, 32'd0, 8'd0);
    query(1'b1, 32'd1000, -32'sd5, 32'd0, 8'd0);
    query(1'b1, 32'd1000, 32'sd0, 32'd0, 8'd0);
    query(1'b1, 32'd0, 32'sd9, 32'd12345, 8'd7);
    write_speed(0, 24'sd8388607);
    query(1'b1, 32'hFFFF_FFFF, 32'sd1, 32'hFFFF_FFFF, 8'd128);
    query(1'b1, 32'hFFFF_FFFF, 32'sd1, 32'd0, 8'd255);
    query(1'b1, 32'd5000000, 32'sh7FFF_FFFF, 32'd230399, 8'd200);
    write_speed(0, -24'sd8388608);
    query(1'b1, 32'd1000, 32'sd321, 32'd100, 8'd1);
    query(1'b1, 32'd1000, -32'sh8000_0000, 32'd100, 8'd1);
    write_speed(0, 24'sd0);
    query(1'b1, 32'd1000, 32'sd0, 32'd100, 8'd1);
    write_speed(0, 24'sd1);
    query(1'b1, 32'hFFFF_FFFF, 32'sd44, 32'd0, 8'd1);
    query(1'b1, 32'd899, 32'sd44, 32'd0, 8'd1);
    write_speed(0, 24'sd256);
    query(1'b1, 32'd300000, 32'sd44, 32'd230000, 8'd2);
    write_speed(127, 24'sd8388607);
    query(1'b1, 32'd123456, 32'sd1, 32'd29260800, 8'd128);
  endtask

  task automatic test_random();
    in_t it;
    for (int i = 0; i < 1100; i++) begin
      if ($urandom_range(0, 9) < 4) begin
        write_speed($urandom_range(0, 127), random_speed());
      end else begin
        it = noise_item();
        it.cmd = CMD_QUERY;
        it.edge_found = ($urandom_range(0, 9) != 0);
        it.edge_length = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 19) == 0) it.edge_length = 0;
        if ($urandom_range(0, 9) != 0) it.slot_count = 8'($urandom_range(1, 128));
        if ($urandom_range(0, 1) == 0) it.start_time = $urandom_range(0, 30000000);
        send_item(it);
      end
      idle_gap();
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    start = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    for (int i = 0; i < 128; i++) profile[i] = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_fill_profile();
    test_directed();
    test_random();
    while (pending_times.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
